// ===== hw/rtl/gap_linear_interpolator_top_defines.svh =====
// ----------------------------------------------------------------------------
// Gap linear interpolator assertion macros
// Shared property forms for the checker of the gap linear interpolator.
// ----------------------------------------------------------------------------
`ifndef GAP_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define GAP_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gli_pkg.sv =====
// ----------------------------------------------------------------------------
// Gap linear interpolator package
// Types, constants and control structures shared by the interpolator files.
// ----------------------------------------------------------------------------
package gli_pkg;

  localparam int GLI_MAX_GAP   = 63;
  localparam int GLI_FRAC_BITS = 16;
  localparam int SAMPLE_W      = 32;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_NOVALID  = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       finite;
    logic                       end_of_record;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       filled;
    logic                       last_of_run;
    status_e                    status;
    logic                       record_done;
    logic [SAMPLE_W-1:0]        fill_total;
  } out_item_t;

  typedef enum logic [2:0] {
    EM_NONE,
    EM_INTERP,
    EM_BACK,
    EM_SAMPLE,
    EM_OVF,
    EM_TRAIL
  } emit_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_INTERP,
    S_BACK,
    S_SAMPLE,
    S_OVF,
    S_TRAIL
  } ctrl_state_e;

  typedef struct packed {
    logic  accept;
    logic  pend_inc;
    logic  div_start;
    emit_e emit;
    logic  last;
    logic  done;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic eor;
    logic have_valid;
    logic pend_zero;
    logic pend_one;
    logic pend_max;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/gli_stream_if.sv =====
// ----------------------------------------------------------------------------
// Gap linear interpolator stream interface
// Valid/ready channel that carries one payload item per transfer.
// ----------------------------------------------------------------------------
interface gli_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/gli_ctrl.sv =====
// ----------------------------------------------------------------------------
// Gap linear interpolator controller
// Sequences accept, division, slot emission and end of record handling.
// ----------------------------------------------------------------------------
module gli_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gli_pkg::sts_t sts_i,
  output gli_pkg::cmd_t cmd_o
);
  import gli_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.emit    = EM_NONE;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts_i.fin) begin
          if (sts_i.pend_zero) begin
            state_d = S_SAMPLE;
          end else if (sts_i.have_valid) begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end else begin
            state_d = S_BACK;
          end
        end else if (sts_i.pend_max) begin
          state_d = S_OVF;
        end else begin
          cmd_o.pend_inc = 1'b1;
          state_d        = sts_i.eor ? S_TRAIL : S_IDLE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          state_d = S_INTERP;
        end
      end
      S_INTERP: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EM_INTERP;
          if (sts_i.pend_one) begin
            state_d = S_SAMPLE;
          end
        end
      end
      S_BACK: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EM_BACK;
          if (sts_i.pend_one) begin
            state_d = S_SAMPLE;
          end
        end
      end
      S_SAMPLE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EM_SAMPLE;
          cmd_o.last = 1'b1;
          cmd_o.done = sts_i.eor;
          state_d    = S_IDLE;
        end
      end
      S_OVF: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EM_OVF;
          cmd_o.last = !sts_i.eor;
          state_d    = sts_i.eor ? S_TRAIL : S_IDLE;
        end
      end
      S_TRAIL: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EM_TRAIL;
          cmd_o.last = sts_i.pend_one;
          cmd_o.done = sts_i.pend_one;
          if (sts_i.pend_one) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/gli_datapath.sv =====
// ----------------------------------------------------------------------------
// Gap linear interpolator datapath
// Record state, bit-serial step divider, slot accumulator and output register.
// ----------------------------------------------------------------------------
module gli_datapath #(
  parameter int MAX_GAP   = gli_pkg::GLI_MAX_GAP,
  parameter int FRAC_BITS = gli_pkg::GLI_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gli_pkg::in_item_t  in_data_i,
  input  gli_pkg::cmd_t      cmd_i,
  output gli_pkg::sts_t      sts_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output gli_pkg::out_item_t out_data_o
);
  import gli_pkg::*;

  localparam int GAP_W = $clog2(MAX_GAP + 1);
  localparam int DVS_W = $clog2(MAX_GAP + 2);
  localparam int DIV_W = SAMPLE_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DIV_W + 1);
  localparam int ACC_W = DIV_W + 2;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       fin_q;
  logic                       eor_q;
  logic signed [SAMPLE_W-1:0] base_q;
  logic                       hv_q;
  logic [GAP_W-1:0]           pend_q;
  logic [SAMPLE_W-1:0]        fcnt_q;
  logic [DIV_W-1:0]           dvd_q;
  logic [DVS_W-1:0]           rem_q;
  logic [DVS_W-1:0]           dvs_q;
  logic                       neg_q;
  logic [CNT_W-1:0]           dcnt_q;
  logic signed [DIV_W:0]      step_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       out_valid_q;
  out_item_t                  out_data_q;

  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0]        mag;
  logic [DVS_W:0]             trial;
  logic                       ge;
  logic [DVS_W-1:0]           rem_d;
  logic signed [DIV_W:0]      step_d;
  logic signed [ACC_W-1:0]    acc_start;
  logic signed [ACC_W-1:0]    acc_sum;
  logic signed [SAMPLE_W-1:0] emit_value;
  logic                       emit_filled;
  status_e                    emit_status;
  logic [SAMPLE_W-1:0]        fcnt_d;
  logic                       out_free;

  always_comb begin
    diff      = $signed({sample_q[SAMPLE_W-1], sample_q})
              - $signed({base_q[SAMPLE_W-1], base_q});
    mag       = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : SAMPLE_W'(diff);
    trial     = {rem_q, dvd_q[DIV_W-1]};
    ge        = trial >= {1'b0, dvs_q};
    rem_d     = ge ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
    step_d    = neg_q ? -$signed({1'b0, dvd_q}) : $signed({1'b0, dvd_q});
    acc_start = ACC_W'(base_q) <<< FRAC_BITS;
    acc_sum   = acc_q + ACC_W'(step_q);
  end

  always_comb begin
    emit_value  = '0;
    emit_filled = 1'b0;
    emit_status = ST_OK;
    case (cmd_i.emit)
      EM_INTERP: begin
        emit_value  = acc_sum[FRAC_BITS +: SAMPLE_W];
        emit_filled = 1'b1;
      end
      EM_BACK: begin
        emit_value  = sample_q;
        emit_filled = 1'b1;
      end
      EM_SAMPLE: begin
        emit_value = sample_q;
      end
      EM_OVF: begin
        emit_value  = base_q;
        emit_filled = 1'b1;
        emit_status = ST_OVERFLOW;
      end
      EM_TRAIL: begin
        if (hv_q) begin
          emit_value  = base_q;
          emit_filled = 1'b1;
        end else begin
          emit_status = ST_NOVALID;
        end
      end
      default: begin
        emit_value = '0;
      end
    endcase
    fcnt_d = (emit_filled && (fcnt_q != '1)) ? fcnt_q + 1'b1 : fcnt_q;
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      hv_q        <= 1'b0;
      pend_q      <= '0;
      fcnt_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.div_start) begin
        dcnt_q <= CNT_W'(DIV_W);
      end else if (dcnt_q != '0) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (cmd_i.emit != EM_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.done) begin
        base_q <= '0;
        hv_q   <= 1'b0;
        pend_q <= '0;
        fcnt_q <= '0;
      end else if (cmd_i.emit != EM_NONE) begin
        fcnt_q <= fcnt_d;
        case (cmd_i.emit)
          EM_INTERP, EM_BACK, EM_TRAIL: begin
            pend_q <= pend_q - 1'b1;
          end
          EM_SAMPLE: begin
            base_q <= sample_q;
            hv_q   <= 1'b1;
            pend_q <= '0;
          end
          default: begin
            pend_q <= pend_q;
          end
        endcase
      end else if (cmd_i.pend_inc) begin
        pend_q <= pend_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    if (cmd_i.accept) begin
      sample_q <= in_data_i.sample;
      fin_q    <= in_data_i.finite;
      eor_q    <= in_data_i.end_of_record;
    end
    if (cmd_i.div_start) begin
      dvd_q <= DIV_W'(mag) << FRAC_BITS;
      rem_q <= '0;
      dvs_q <= DVS_W'(pend_q) + 1'b1;
      neg_q <= diff[SAMPLE_W];
      acc_q <= acc_start;
    end else begin
      if (dcnt_q != '0) begin
        dvd_q <= {dvd_q[DIV_W-2:0], ge};
        rem_q <= rem_d;
      end
      if (cmd_i.emit == EM_INTERP) begin
        acc_q <= acc_sum;
      end
    end
    if (cmd_i.emit != EM_NONE) begin
      out_data_q.value       <= emit_value;
      out_data_q.filled      <= emit_filled;
      out_data_q.last_of_run <= cmd_i.last;
      out_data_q.status      <= emit_status;
      out_data_q.record_done <= cmd_i.done;
      out_data_q.fill_total  <= cmd_i.done ?
                                ((emit_status == ST_NOVALID) ? '1 : fcnt_d) : '0;
    end
  end

  always_comb begin
    sts_o.fin        = fin_q;
    sts_o.eor        = eor_q;
    sts_o.have_valid = hv_q;
    sts_o.pend_zero  = (pend_q == '0);
    sts_o.pend_one   = (pend_q == GAP_W'(1));
    sts_o.pend_max   = (pend_q == GAP_W'(MAX_GAP));
    sts_o.div_done   = (dcnt_q == '0);
    sts_o.out_free   = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hw/rtl/gap_linear_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// Gap linear interpolator top level
// Fills invalid samples of a Q16.16 record by linear interpolation.
// ----------------------------------------------------------------------------
// Samples enter on in_i, one transfer per sample, and results leave on out_o.
// An input is taken only while the block is idle; it then passes through the
// dispatch state before any result is produced.
// A finite sample after a gap of n invalid samples runs a bit-serial divider
// if a valid sample came before it (else the slots copy the new sample), then
// emits the n slots and the sample itself at one result per cycle while the receiver is ready.
// Without a gap a finite sample yields its single result.
// An invalid sample that only grows the gap yields no result; an end of record
// adds one result per trailing slot.
// Results pass through a single output register; while the receiver holds
// ready low, that register keeps its result and the sequence waits.
// Reset clears the record state and leaves the block idle and ready.
// ----------------------------------------------------------------------------
module gap_linear_interpolator_top #(
  parameter int MAX_GAP   = gli_pkg::GLI_MAX_GAP,
  parameter int FRAC_BITS = gli_pkg::GLI_FRAC_BITS
) (
  input logic   clk_i,
  input logic   rst_ni,
  gli_stream_if.sink   in_i,
  gli_stream_if.source out_o
);
  import gli_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gli_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gli_datapath #(
    .MAX_GAP   (MAX_GAP),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );

endmodule

// ===== hw/rtl/gli_checker.sv =====
// ----------------------------------------------------------------------------
// Gap linear interpolator checker
// Port level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "gap_linear_interpolator_top_defines.svh"

module gli_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input gli_pkg::out_item_t out_data_i
);
  import gli_pkg::*;

  `GLI_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "Stalled result changed before its transfer.")
  `GLI_ASSERT_IMP(a_done_last, out_valid_i && out_data_i.record_done, out_data_i.last_of_run, "Record end without end of run.")
  `GLI_ASSERT_IMP(a_total_zero, out_valid_i && !out_data_i.record_done, out_data_i.fill_total == '0, "Fill total shown before record end.")
  `GLI_ASSERT_IMP(a_novalid, out_valid_i && (out_data_i.status == ST_NOVALID), !out_data_i.filled && (out_data_i.value == '0), "No-valid slot carries data.")

endmodule

bind gap_linear_interpolator_top gli_checker u_gli_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
